FILE: rtl/alr_pkg.sv
// Shared constants, types and codes of the audio linear resampler.
package alr_pkg;

  // Rates and limits
  localparam int unsigned OUT_RATE    = 48000;
  localparam int unsigned MAX_OUT     = 8192;
  localparam int unsigned MIN_RATE    = (OUT_RATE + 5) / 6;
  localparam int unsigned GAIN_MAX    = 65536;
  localparam int unsigned MAX_RESULTS = 12;
  localparam int unsigned MAX_QRATE   = 5;     // largest rate / OUT_RATE for 18-bit rate
  localparam int unsigned SAT_NEG     = 32768; // magnitude of the most negative sample

  // Field widths
  localparam int SMP_W   = 16;
  localparam int RATE_W  = 18;
  localparam int NFR_W   = 16;
  localparam int GAIN_W  = 17;
  localparam int CNT_W   = 14;
  localparam int PH_W    = 16;
  localparam int REM_W   = 16;
  localparam int QR_W    = 3;
  localparam int RCNT_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 18;

  // Block total divider
  localparam int NUM_W   = 33;
  localparam int DEN_W   = 19;
  localparam int QUO_W   = 14;
  localparam int QBITS   = 13;
  localparam int QCNT_W  = 4;

  // Channel datapath: divide by OUT_RATE*16384 = 375 * 2^21
  localparam int PROD1_W     = 33;
  localparam int MAG_W       = 31;
  localparam int PROD_W      = 48;
  localparam int PRE_SHIFT   = 21;
  localparam int X_W         = 26;
  localparam int RECIP_W     = 27;
  localparam int Y_W         = 53;
  localparam int RECIP_SHIFT = 35;
  localparam int Q_W         = 18;
  localparam logic [RECIP_W-1:0] RECIP_M = 27'd91625969; // ceil(2^35 / 375)
  localparam int LANE_DEPTH  = 4;

  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7fff;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MONO = 2'd0,
    CFG_RATE = 2'd1,
    CFG_NFR  = 2'd2,
    CFG_GAIN = 2'd3
  } alr_cfg_idx_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_GEN
  } alr_state_t;

  typedef struct packed {
    logic              mono;
    logic [RATE_W-1:0] rate;
    logic [NFR_W-1:0]  nfr;
    logic [GAIN_W-1:0] gain;
  } alr_cfg_t;

  // One output frame handed to the channel lanes
  typedef struct packed {
    logic                    valid;
    logic                    blk_end;
    logic signed [SMP_W-1:0] a_l;
    logic signed [SMP_W-1:0] b_l;
    logic signed [SMP_W-1:0] a_r;
    logic signed [SMP_W-1:0] b_r;
    logic [REM_W-1:0]        rem;
  } alr_issue_t;

endpackage

FILE: rtl/alr_div.sv
// Iterative restoring divider for the per-block output total, capped at MAX_OUT.
module alr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [alr_pkg::NUM_W-1:0]   num,
  input  logic [alr_pkg::DEN_W-1:0]   den,
  output logic                        done,
  output logic [alr_pkg::QUO_W-1:0]   quot
);
  import alr_pkg::*;

  logic              busy_r;
  logic              chk_r;
  logic              done_r;
  logic [QCNT_W-1:0] bit_r;
  logic [NUM_W-1:0]  rem_r;
  logic [NUM_W-1:0]  dsr_r;
  logic [QBITS-1:0]  q_r;
  logic [QUO_W-1:0]  quot_r;
  logic              ge;
  logic [QBITS-1:0]  q_nxt;

  assign ge    = rem_r >= dsr_r;
  assign q_nxt = {q_r[QBITS-2:0], ge};

  // Control: a cap check first, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      chk_r  <= 1'b0;
      done_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        chk_r  <= 1'b1;
        bit_r  <= QCNT_W'(QBITS - 1);
      end else if (busy_r) begin
        if (chk_r) begin
          chk_r <= 1'b0;
          if (ge) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end else begin
          bit_r <= bit_r - QCNT_W'(1);
          if (bit_r == '0) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsr_r <= NUM_W'({den, {QBITS{1'b0}}});
      q_r   <= '0;
    end else if (busy_r) begin
      dsr_r <= dsr_r >> 1;
      if (chk_r) begin
        if (ge) quot_r <= QUO_W'(MAX_OUT);
      end else begin
        q_r <= q_nxt;
        if (ge) rem_r <= rem_r - dsr_r;
        if (bit_r == '0) quot_r <= {1'b0, q_nxt};
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

FILE: rtl/alr_lane.sv
// One channel lane: interpolate, apply gain, divide by constant and saturate.
module alr_lane (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [alr_pkg::SMP_W-1:0]   a,
  input  logic signed [alr_pkg::SMP_W-1:0]   b,
  input  logic [alr_pkg::REM_W-1:0]          rem,
  input  logic [alr_pkg::GAIN_W-1:0]         gain,
  output logic signed [alr_pkg::SMP_W-1:0]   y
);
  import alr_pkg::*;

  logic [REM_W-1:0]          wa;
  logic signed [PROD1_W-1:0] pa_r;
  logic signed [PROD1_W-1:0] pb_r;
  logic signed [PROD1_W-1:0] sum;
  logic [PROD1_W-1:0]        sum_abs;
  logic [MAG_W-1:0]          mag_r;
  logic                      neg2_r;
  logic [PROD_W-1:0]         prod_r;
  logic                      neg3_r;
  logic [Y_W-1:0]            y_r;
  logic                      neg4_r;
  logic [Q_W-1:0]            q;
  logic [Q_W-1:0]            q_neg;

  assign wa      = REM_W'(OUT_RATE) - rem;
  assign sum     = pa_r + pb_r;
  assign sum_abs = sum[PROD1_W-1] ? (PROD1_W'(0) - sum) : sum;

  // Four registered stages, all held while the output side stalls
  always_ff @(posedge clk) begin
    if (en) begin
      // weights
      pa_r   <= $signed({{(PROD1_W-SMP_W){a[SMP_W-1]}}, a}) *
                $signed({{(PROD1_W-REM_W){1'b0}}, wa});
      pb_r   <= $signed({{(PROD1_W-SMP_W){b[SMP_W-1]}}, b}) *
                $signed({{(PROD1_W-REM_W){1'b0}}, rem});
      // sign and magnitude
      neg2_r <= sum[PROD1_W-1];
      mag_r  <= sum_abs[MAG_W-1:0];
      // gain
      neg3_r <= neg2_r;
      prod_r <= PROD_W'(mag_r) * PROD_W'(gain);
      // divide by 375 via reciprocal, after dropping 2^21
      neg4_r <= neg3_r;
      y_r    <= Y_W'(prod_r[PRE_SHIFT +: X_W]) * Y_W'(RECIP_M);
    end
  end

  // Restore sign (truncation toward zero) and saturate
  assign q     = y_r[RECIP_SHIFT +: Q_W];
  assign q_neg = Q_W'(0) - q;

  always_comb begin
    if (neg4_r) begin
      if (q > Q_W'(SAT_NEG)) y = SMP_MIN;
      else                   y = $signed(q_neg[SMP_W-1:0]);
    end else begin
      if (q > Q_W'(SMP_MAX)) y = SMP_MAX;
      else                   y = $signed(q[SMP_W-1:0]);
    end
  end

endmodule

FILE: rtl/alr_ctrl.sv
// Phase sequencer: tracks the block, computes its total and issues output frames.
module alr_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [alr_pkg::SMP_W-1:0]  in_left,
  input  logic signed [alr_pkg::SMP_W-1:0]  in_right,
  input  alr_pkg::alr_cfg_t                 cfg,
  input  logic                              en,
  output logic                              in_ready,
  output alr_pkg::alr_issue_t               issue
);
  import alr_pkg::*;

  alr_state_t state_r, state_nxt;

  logic signed [SMP_W-1:0] cur_l_r, cur_r_r, held_l_r, held_r_r;
  logic [NFR_W-1:0]  in_cnt_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic [CNT_W-1:0]  total_r;
  logic [PH_W-1:0]   phase_r;
  logic [REM_W-1:0]  prem_r;
  logic [RCNT_W-1:0] cnt_r;
  logic              last_r;
  logic [QR_W-1:0]   qrate_r;
  logic [REM_W-1:0]  rrate_r;

  logic              accept;
  logic              blk_start;
  logic              div_go;
  logic              div_done;
  logic [QUO_W-1:0]  div_quot;
  logic              do_issue;
  logic              finish;
  logic              more;
  logic              use_held;
  logic [RATE_W-1:0] rate_e;
  logic [QR_W-1:0]   qrate_c;
  logic [REM_W-1:0]  rrate_c;
  logic [NUM_W-1:0]  num_c;
  logic [DEN_W-1:0]  den_c;
  logic              last_c;
  logic [REM_W:0]    adv;
  logic              wrap;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready && (cfg.nfr != '0);
  assign blk_start = (in_cnt_r == '0);

  // Effective rate and its split by OUT_RATE
  always_comb begin
    if (cfg.rate == '0)                     rate_e = RATE_W'(OUT_RATE);
    else if (cfg.rate < RATE_W'(MIN_RATE))  rate_e = RATE_W'(MIN_RATE);
    else                                    rate_e = cfg.rate;
    qrate_c = '0;
    for (int k = 1; k <= MAX_QRATE; k++) begin
      if (rate_e >= RATE_W'(k * OUT_RATE)) qrate_c = QR_W'(k);
    end
    rrate_c = REM_W'(rate_e - RATE_W'(qrate_c) * RATE_W'(OUT_RATE));
  end

  // Total = floor((2*n*OUT_RATE + rate) / (2*rate))
  assign num_c  = NUM_W'(cfg.nfr) * NUM_W'(2 * OUT_RATE) + NUM_W'(rate_e);
  assign den_c  = {rate_e, 1'b0};
  assign last_c = ({1'b0, in_cnt_r} + (NFR_W+1)'(1)) >= {1'b0, cfg.nfr};

  alr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (num_c),
    .den   (den_c),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Output frame selection
  assign use_held = phase_r < in_cnt_r;
  assign more     = (out_cnt_r < total_r) && (cnt_r < RCNT_W'(MAX_RESULTS)) &&
                    (use_held || last_r);
  assign adv      = {1'b0, prem_r} + {1'b0, rrate_r};
  assign wrap     = adv >= (REM_W+1)'(OUT_RATE);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state and strobes
  always_comb begin
    state_nxt = state_r;
    div_go    = 1'b0;
    do_issue  = 1'b0;
    finish    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (blk_start) begin
            div_go    = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_GEN;
          end
        end
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_GEN;
      end
      ST_GEN: begin
        if (!more) begin
          finish    = 1'b1;
          state_nxt = ST_IDLE;
        end else if (en) begin
          do_issue = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_l_r  <= '0;
      held_r_r  <= '0;
      in_cnt_r  <= '0;
      out_cnt_r <= '0;
      total_r   <= '0;
      phase_r   <= '0;
      prem_r    <= '0;
      cnt_r     <= '0;
    end else begin
      if (accept) begin
        cnt_r <= '0;
        if (blk_start) begin
          out_cnt_r <= '0;
          phase_r   <= '0;
          prem_r    <= '0;
        end
      end
      if (state_r == ST_DIV && div_done) total_r <= div_quot;
      if (do_issue) begin
        out_cnt_r <= out_cnt_r + CNT_W'(1);
        cnt_r     <= cnt_r + RCNT_W'(1);
        phase_r   <= phase_r + PH_W'(qrate_r) + PH_W'(wrap);
        prem_r    <= wrap ? REM_W'(adv - (REM_W+1)'(OUT_RATE)) : adv[REM_W-1:0];
      end
      if (finish) begin
        held_l_r <= cur_l_r;
        held_r_r <= cur_r_r;
        in_cnt_r <= last_r ? '0 : in_cnt_r + NFR_W'(1);
      end
    end
  end

  // Per-item values captured at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_l_r <= in_left;
      cur_r_r <= cfg.mono ? in_left : in_right;
      last_r  <= last_c;
      qrate_r <= qrate_c;
      rrate_r <= rrate_c;
    end
  end

  // Frame handed to the lanes
  always_comb begin
    issue.valid   = do_issue;
    issue.blk_end = ((out_cnt_r + CNT_W'(1)) == total_r);
    issue.a_l     = use_held ? held_l_r : cur_l_r;
    issue.b_l     = cur_l_r;
    issue.a_r     = use_held ? held_r_r : cur_r_r;
    issue.b_r     = cur_r_r;
    issue.rem     = prem_r;
  end

endmodule

FILE: rtl/audio_linear_resampler.sv
// Top level: configuration registers, sequencer, two channel lanes and output merge.
// Throughput: an item yields its m output frames (m <= 12) one per cycle from the shared
//   phase sequencer while the output does not stall; the first item of a block first waits
//   for the iterative total divider, which ends early when the total is capped.
// Pipeline: an output frame passes the four lane stages and the output register after the
//   sequencer issues it; output stalls hold the whole pipeline.
// Reset: synchronous, active low; clears block state, config to defaults, no output.
module audio_linear_resampler (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [31:0]                      in_tdata,   // [15:0] left_sample, [31:16] right_sample
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [31:0]                      out_tdata,  // [15:0] out_left, [31:16] out_right
  output logic                             out_tlast,  // block_end
  input  logic                             cfg_we,
  input  logic [alr_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [alr_pkg::CFG_DAT_W-1:0]    cfg_wdata
);
  import alr_pkg::*;

  alr_cfg_t                cfg_r;
  alr_issue_t              issue;
  logic [GAIN_W-1:0]       gain_sat;
  logic                    en;
  logic [LANE_DEPTH-1:0]   v_r;
  logic [LANE_DEPTH-1:0]   be_r;
  logic signed [SMP_W-1:0] lane_l_y, lane_r_y;
  logic                    out_valid_r;
  logic                    out_last_r;
  logic signed [SMP_W-1:0] out_left_r, out_right_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mono <= 1'b0;
      cfg_r.rate <= RATE_W'(OUT_RATE);
      cfg_r.nfr  <= NFR_W'(256);
      cfg_r.gain <= GAIN_W'(16384);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MONO: cfg_r.mono <= cfg_wdata[0];
        CFG_RATE: cfg_r.rate <= cfg_wdata[RATE_W-1:0];
        CFG_NFR:  cfg_r.nfr  <= cfg_wdata[NFR_W-1:0];
        CFG_GAIN: cfg_r.gain <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign gain_sat = (cfg_r.gain > GAIN_W'(GAIN_MAX)) ? GAIN_W'(GAIN_MAX) : cfg_r.gain;

  // Pipeline advances when the output register is free or being drained
  assign en = !out_valid_r || out_tready;

  alr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_left  ($signed(in_tdata[15:0])),
    .in_right ($signed(in_tdata[31:16])),
    .cfg      (cfg_r),
    .en       (en),
    .in_ready (in_tready),
    .issue    (issue)
  );

  alr_lane u_lane_l (
    .clk  (clk),
    .en   (en),
    .a    (issue.a_l),
    .b    (issue.b_l),
    .rem  (issue.rem),
    .gain (gain_sat),
    .y    (lane_l_y)
  );

  alr_lane u_lane_r (
    .clk  (clk),
    .en   (en),
    .a    (issue.a_r),
    .b    (issue.b_r),
    .rem  (issue.rem),
    .gain (gain_sat),
    .y    (lane_r_y)
  );

  // Valid and block-end flags travel beside the lane stages
  always_ff @(posedge clk) begin
    if (!rst_n)  v_r <= '0;
    else if (en) v_r <= {v_r[LANE_DEPTH-2:0], issue.valid};
  end

  always_ff @(posedge clk) begin
    if (en) be_r <= {be_r[LANE_DEPTH-2:0], issue.blk_end};
  end

  // Merge both lanes into the output register
  always_ff @(posedge clk) begin
    if (!rst_n)  out_valid_r <= 1'b0;
    else if (en) out_valid_r <= v_r[LANE_DEPTH-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_left_r  <= lane_l_y;
      out_right_r <= lane_r_y;
      out_last_r  <= be_r[LANE_DEPTH-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_right_r, out_left_r};
  assign out_tlast  = out_last_r;

endmodule

FILE: rtl/alr_chk.sv
// Port-level checker for the resampler, bound to the top level.
module alr_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [31:0]                      out_tdata,
  input logic                             out_tlast,
  input logic                             cfg_we,
  input logic [alr_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input logic [alr_pkg::CFG_DAT_W-1:0]    cfg_wdata
);
  import alr_pkg::*;

  logic [NFR_W-1:0] nfr_r;
  logic             in_xact;

  assign in_xact = in_tvalid && in_tready;

  // Shadow of the block size register
  always_ff @(posedge clk) begin
    if (!rst_n)                             nfr_r <= NFR_W'(256);
    else if (cfg_we && cfg_idx == CFG_NFR)  nfr_r <= cfg_wdata[NFR_W-1:0];
  end

  // A stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output transaction changed while stalled");

  // Reset leaves the block ready with no pending output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

  // An item of a nonempty block keeps the input busy for its work
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xact && nfr_r != '0 |=> !in_tready)
    else $error("input ready right after accepting a frame");

  // With an empty block size, frames are dropped and the input stays ready
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_xact && nfr_r == '0 |=> in_tready && !out_tvalid)
    else $error("empty block size frame was not dropped");

endmodule

bind audio_linear_resampler alr_chk u_alr_chk (.*);

FILE: tb/sv/tb_audio_linear_resampler.sv
// Self-checking testbench for the audio linear resampler: directed table, random blocks, predictor.
`timescale 1ns / 100ps

module tb_audio_linear_resampler;

  // Resampler constants used by the predictor
  localparam int unsigned OUT_HZ       = 48000;
  localparam int unsigned LOW_HZ       = 8000;   // nonzero rates below this are raised to it
  localparam int unsigned CAP_FRAMES   = 8192;
  localparam int unsigned GAIN_CAP     = 65536;
  localparam int unsigned UNITY        = 16384;
  localparam int unsigned MAX_PER_ITEM = 12;

  // Run control
  localparam int unsigned RAND_ITEMS   = 110;
  localparam int unsigned CAP_BLOCK    = 1366;   // smallest block that hits the output cap at LOW_HZ
  localparam int unsigned CAP_ITEMS    = 12;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned WD_LIMIT     = 3000;
  localparam int          DIR_ROWS     = 42;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               blk_end;
  } frame_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  // One directed step: a register write, or a frame with an optional typed-in result
  typedef struct packed {
    row_kind_t             kind;
    alr_pkg::alr_cfg_idx_t idx;
    logic [17:0]           val;
    logic [15:0]           l;
    logic [15:0]           r;
    logic                  typed;
    frame_t                want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;       // [15:0] left_sample, [31:16] right_sample
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // [15:0] out_left, [31:16] out_right
  logic        out_tlast;           // block_end
  logic        cfg_we = 1'b0;
  alr_pkg::alr_cfg_idx_t           cfg_idx = alr_pkg::CFG_MONO;
  logic [alr_pkg::CFG_DAT_W-1:0]   cfg_wdata = '0;

  frame_t      pending_frames[$];
  int unsigned err_cnt = 0;
  int unsigned frames_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sink_hold_cnt = 0;
  bit          hold_req = 1'b0;
  bit          calm = 1'b0;

  // Predictor copy of registers and block state
  logic               m_mono;
  logic [17:0]        m_rate;
  logic [15:0]        m_nfr;
  logic [16:0]        m_gain;
  logic signed [15:0] m_held_l, m_held_r;
  int unsigned        m_in_cnt, m_out_cnt, m_ph_idx, m_ph_rem, m_total;

  audio_linear_resampler uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void model_reset();
    m_mono    = 1'b0;
    m_rate    = 18'd48000;
    m_nfr     = 16'd256;
    m_gain    = 17'(UNITY);
    m_held_l  = '0;
    m_held_r  = '0;
    m_in_cnt  = 0;
    m_out_cnt = 0;
    m_ph_idx  = 0;
    m_ph_rem  = 0;
    m_total   = 0;
  endfunction

  function automatic void apply_reg(alr_pkg::alr_cfg_idx_t idx, logic [17:0] v);
    case (idx)
      alr_pkg::CFG_MONO: m_mono = v[0];
      alr_pkg::CFG_RATE: m_rate = v;
      alr_pkg::CFG_NFR:  m_nfr  = v[15:0];
      alr_pkg::CFG_GAIN: m_gain = v[16:0];
      default: ;
    endcase
  endfunction

  // Weighted blend of two frames, scaled by gain, truncated toward zero, saturated
  function automatic logic signed [15:0] mix_lane(logic signed [15:0] a, logic signed [15:0] b,
                                                  int unsigned rem, int unsigned g);
    longint acc;
    longint v;
    acc = longint'(a) * (longint'(OUT_HZ) - longint'(rem)) + longint'(b) * longint'(rem);
    v   = (acc * longint'(g)) / (longint'(OUT_HZ) * longint'(UNITY));
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Output frames caused by one accepted source frame
  function automatic void resample_step(input logic signed [15:0] l, input logic signed [15:0] r,
                                        ref frame_t outs[$]);
    int unsigned        rate, g, k, adv;
    longint unsigned    tot;
    logic               last;
    logic signed [15:0] cl, cr, al, ar, bl, br;
    frame_t             f;
    outs.delete();
    if (m_nfr == 0) return;
    rate = (m_rate == 0) ? OUT_HZ : m_rate;
    if (rate < LOW_HZ) rate = LOW_HZ;
    g  = (m_gain > GAIN_CAP) ? GAIN_CAP : m_gain;
    cl = l;
    cr = m_mono ? l : r;
    k  = m_in_cnt;
    // block start: rounded output total, capped
    if (k == 0) begin
      tot = (longint'(m_nfr) * 2 * OUT_HZ + rate) / (longint'(rate) * 2);
      if (tot > CAP_FRAMES) tot = CAP_FRAMES;
      m_total   = 32'(tot);
      m_out_cnt = 0;
      m_ph_idx  = 0;
      m_ph_rem  = 0;
    end
    last = (k + 1 >= m_nfr);
    while (m_out_cnt < m_total && outs.size() < MAX_PER_ITEM) begin
      if (m_ph_idx < k) begin
        al = m_held_l; ar = m_held_r;
        bl = cl;       br = cr;
      end else if (last) begin
        al = cl; ar = cr;
        bl = cl; br = cr;
      end else begin
        break;
      end
      f.left  = mix_lane(al, bl, m_ph_rem, g);
      f.right = mix_lane(ar, br, m_ph_rem, g);
      m_out_cnt++;
      f.blk_end = (m_out_cnt == m_total);
      outs.push_back(f);
      adv      = m_ph_rem + rate;
      m_ph_idx += adv / OUT_HZ;
      m_ph_rem = adv % OUT_HZ;
    end
    m_held_l = cl;
    m_held_r = cr;
    m_in_cnt = last ? 0 : k + 1;
  endfunction

  function automatic dir_row_t cfg_row(alr_pkg::alr_cfg_idx_t idx, logic [17:0] v);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.val  = v;
    return row;
  endfunction

  function automatic dir_row_t item_row(logic [15:0] l, logic [15:0] r);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_ITEM;
    row.l    = l;
    row.r    = r;
    return row;
  endfunction

  function automatic dir_row_t chk_row(logic [15:0] l, logic [15:0] r,
                                       logic [15:0] el, logic [15:0] er, logic last);
    dir_row_t row;
    row              = item_row(l, r);
    row.typed        = 1'b1;
    row.want.left    = el;
    row.want.right   = er;
    row.want.blk_end = last;
    return row;
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(15))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic report_miss(input string what);
    $display("%0t: mismatch: %s", $time, what);
    err_cnt++;
  endtask

  // Offer one source frame; predict its output frames once the transaction completes
  task automatic offer_frame(input logic [15:0] l, input logic [15:0] r,
                             input logic typed, input frame_t want);
    int unsigned gap;
    frame_t      got[$];
    gap = 0;
    while (!calm && gap < 20 && $urandom_range(99) < 33) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r, l};
    do @(posedge clk); while (!in_tready);
    resample_step(l, r, got);
    if (typed) begin
      if (got.size() != 1)
        report_miss($sformatf("table row %h/%h predicts %0d frames", l, r, got.size()));
      pending_frames.push_back(want);
    end else begin
      foreach (got[i]) pending_frames.push_back(got[i]);
    end
  endtask

  // Stop offering, wait for every expected frame, then let the pipeline drain
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input alr_pkg::alr_cfg_idx_t idx, input logic [17:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    apply_reg(idx, v);
  endtask

  task automatic program_block(input int unsigned mono, input int unsigned rate,
                               input int unsigned nfr, input int unsigned gain);
    settle();
    write_reg(alr_pkg::CFG_MONO, 18'(mono));
    write_reg(alr_pkg::CFG_RATE, 18'(rate));
    write_reg(alr_pkg::CFG_NFR,  18'(nfr));
    write_reg(alr_pkg::CFG_GAIN, 18'(gain));
    cfg_we <= 1'b0;
  endtask

  // Output side: check each transaction against the oldest expected frame, pace tready
  always @(posedge clk) begin
    frame_t seen;
    frame_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen.left    = out_tdata[15:0];
        seen.right   = out_tdata[31:16];
        seen.blk_end = out_tlast;
        if (pending_frames.size() == 0) begin
          report_miss($sformatf("frame %0d unexpected: %h/%h last %b",
                                frames_seen, seen.left, seen.right, seen.blk_end));
        end else begin
          want = pending_frames.pop_front();
          if (seen.left !== want.left)
            report_miss($sformatf("frame %0d left %h, want %h",
                                  frames_seen, seen.left, want.left));
          if (seen.right !== want.right)
            report_miss($sformatf("frame %0d right %h, want %h",
                                  frames_seen, seen.right, want.right));
          if (seen.blk_end !== want.blk_end)
            report_miss($sformatf("frame %0d block_end %b, want %b",
                                  frames_seen, seen.blk_end, want.blk_end));
        end
        frames_seen++;
      end
      // long hold-off on request, else random back-pressure unless calm
      if (sink_hold_cnt != 0) begin
        out_tready <= 1'b0;
        sink_hold_cnt--;
      end else if (hold_req) begin
        hold_req      = 1'b0;
        sink_hold_cnt = HOLD_CYCLES;
        out_tready    <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 33);
      end
    end
  end

  // Watchdog: too long with no transaction on either stream
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WD_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus
  initial begin
    dir_row_t    dir_tab [DIR_ROWS];
    bit          writing;
    int unsigned rand_items, phase, count;
    int unsigned mono, rate, nfr, gain;

    // At unity gain and 48 kHz each frame returns the previous one
    dir_tab = '{
      item_row(16'h7fff, 16'h8000),
      chk_row (16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1'b0),
      chk_row (16'h1234, 16'hedcb, 16'h8000, 16'h7fff, 1'b0),
      chk_row (16'h0000, 16'h0000, 16'h1234, 16'hedcb, 1'b0),
      cfg_row (alr_pkg::CFG_GAIN, 18'd65536),
      chk_row (16'h1000, 16'hf000, 16'h0000, 16'h0000, 1'b0),
      chk_row (16'h7fff, 16'h8000, 16'h4000, 16'hc000, 1'b0),
      chk_row (16'h0000, 16'h0000, 16'h7fff, 16'h8000, 1'b0),
      // gain above 4.0 saturates
      cfg_row (alr_pkg::CFG_GAIN, 18'h1ffff),
      chk_row (16'h2000, 16'he000, 16'h0000, 16'h0000, 1'b0),
      chk_row (16'h0000, 16'h0000, 16'h7fff, 16'h8000, 1'b0),
      cfg_row (alr_pkg::CFG_GAIN, 18'd0),
      chk_row (16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 1'b0),
      cfg_row (alr_pkg::CFG_GAIN, 18'd16384),
      cfg_row (alr_pkg::CFG_MONO, 18'd1),
      chk_row (16'h4321, 16'h1111, 16'h7fff, 16'h7fff, 1'b0),
      chk_row (16'h0001, 16'h5555, 16'h4321, 16'h4321, 1'b0),
      // block size cut mid-block: the next frame closes it with a full burst
      cfg_row (alr_pkg::CFG_MONO, 18'd0),
      cfg_row (alr_pkg::CFG_NFR,  18'd1),
      item_row(16'h5555, 16'haaaa),
      chk_row (16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b1),
      // zero total, zero rate, low rate, top of the rate field
      cfg_row (alr_pkg::CFG_RATE, 18'd192000),
      item_row(16'h1111, 16'h2222),
      cfg_row (alr_pkg::CFG_RATE, 18'd0),
      chk_row (16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b1),
      cfg_row (alr_pkg::CFG_RATE, 18'd100),
      item_row(16'h2468, 16'h8642),
      cfg_row (alr_pkg::CFG_RATE, 18'h3ffff),
      cfg_row (alr_pkg::CFG_NFR,  18'd4),
      item_row(16'hffff, 16'h0000),
      item_row(16'h0000, 16'hffff),
      item_row(16'h7fff, 16'h8000),
      item_row(16'h8000, 16'h7fff),
      // empty block size: frames ignored
      cfg_row (alr_pkg::CFG_NFR,  18'd0),
      item_row(16'h7fff, 16'h7fff),
      cfg_row (alr_pkg::CFG_NFR,  18'd3),
      cfg_row (alr_pkg::CFG_RATE, 18'd44100),
      cfg_row (alr_pkg::CFG_GAIN, 18'd20000),
      cfg_row (alr_pkg::CFG_MONO, 18'd1),
      item_row(16'h1357, 16'h9bdf),
      item_row(16'hace0, 16'h0246),
      item_row(16'h8000, 16'h1234)
    };

    model_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    writing = 1'b0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        if (!writing) settle();
        writing = 1'b1;
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        if (writing) cfg_we <= 1'b0;
        writing = 1'b0;
        offer_frame(dir_tab[i].l, dir_tab[i].r, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // Random blocks; first phase runs under a long sink hold-off, second without idling
    rand_items = 0;
    phase      = 0;
    while (rand_items < RAND_ITEMS) begin
      if (phase == 0) begin
        mono = 0; rate = 48000; nfr = 8; gain = UNITY; count = 40;
      end else begin
        mono = $urandom_range(1);
        case ($urandom_range(9))
          0:       rate = 8000;
          1:       rate = 192000;
          2:       rate = 0;
          3:       rate = $urandom_range(7999, 1);
          4:       rate = $urandom_range(262143, 192001);
          5:       rate = 44100;
          default: rate = $urandom_range(192000, 8000);
        endcase
        case ($urandom_range(19))
          0:       nfr = 0;
          1:       nfr = 65535;
          2, 3:    nfr = $urandom_range(64, 13);
          default: nfr = $urandom_range(12, 1);
        endcase
        case ($urandom_range(7))
          0:       gain = 0;
          1:       gain = GAIN_CAP;
          2:       gain = UNITY;
          3:       gain = $urandom_range(131071, 65537);
          default: gain = $urandom_range(65536, 0);
        endcase
        // whole blocks mostly; sometimes a trailing partial block left open
        if (nfr == 0) begin
          count = 4;
        end else if (nfr > 12) begin
          count = $urandom_range(20, 5);
        end else begin
          count = nfr * $urandom_range(3, 1);
          if ($urandom_range(3) == 0) count += $urandom_range(nfr, 1);
        end
      end
      program_block(mono, rate, nfr, gain);
      if (phase == 0) hold_req = 1'b1;
      calm = (phase == 1);
      repeat (count) begin
        offer_frame(pick_sample(), pick_sample(), 1'b0, '0);
        if (nfr != 0) rand_items++;
      end
      phase++;
    end
    calm = 1'b0;

    // A block large enough that its total is capped; only its head is sent
    program_block($urandom_range(1), LOW_HZ, CAP_BLOCK, $urandom_range(65536, 0));
    repeat (CAP_ITEMS) offer_frame(pick_sample(), pick_sample(), 1'b0, '0);

    settle();
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
